### hdl/kibs_pkg.sv
`default_nettype none

package kibs_pkg;

  localparam int unsigned NUM_BUTTONS = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IDLE_W      = 16;
  localparam int unsigned BRIGHT_W    = 8;
  localparam int unsigned INPUT_BITS  = 16;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM   = 3'd0,
    REG_OFF   = 3'd1,
    REG_WAKE  = 3'd2,
    REG_FULL  = 3'd3,
    REG_MID   = 3'd4,
    REG_LOW   = 3'd5,
    REG_EMPTY = 3'd6
  } kibs_reg_e;

  localparam logic [1:0] LVL_EMPTY = 2'd0;
  localparam logic [1:0] LVL_LOW   = 2'd1;
  localparam logic [1:0] LVL_MID   = 2'd2;
  localparam logic [1:0] LVL_FULL  = 2'd3;

  localparam logic [IDLE_W-1:0]   DIM_RST    = 16'd200;
  localparam logic [IDLE_W-1:0]   OFF_RST    = 16'd1200;
  localparam logic [BRIGHT_W-1:0] WAKE_RST   = 8'd255;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 8'd255;

  localparam int unsigned FULL_RST  = 4000;
  localparam int unsigned MID_RST   = 3700;
  localparam int unsigned LOW_RST   = 3500;
  localparam int unsigned EMPTY_RST = 3300;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } kibs_cfg_wr_t;

  typedef struct packed {
    logic [1:0] level;
    logic       update;
    logic       shutdown;
  } kibs_bat_stat_t;

  typedef struct packed {
    logic                key_valid;
    logic [2:0]          key_code;
    logic [BRIGHT_W-1:0] display_brightness;
    logic                standby_request;
    logic [1:0]          battery_level;
    logic                level_update;
    logic                low_battery_off;
  } kibs_res_t;

endpackage

`default_nettype wire

### hdl/kibs_if.sv
`default_nettype none

interface kibs_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  button_mask;
  logic [15:0] battery_sample;

  modport source (output valid, output button_mask, output battery_sample, input ready);
  modport sink   (input valid, input button_mask, input battery_sample, output ready);
endinterface

interface kibs_out_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [2:0] key_code;
  logic [7:0] display_brightness;
  logic       standby_request;
  logic [1:0] battery_level;
  logic       level_update;
  logic       low_battery_off;

  modport source (
    output valid, output key_valid, output key_code, output display_brightness,
    output standby_request, output battery_level, output level_update,
    output low_battery_off, input ready
  );
  modport sink (
    input valid, input key_valid, input key_code, input display_brightness,
    input standby_request, input battery_level, input level_update,
    input low_battery_off, output ready
  );
endinterface

interface kibs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/keypad_idle_battery_supervisor.sv
// Datapath: an item passes the input register, then the result register.
// Throughput: one item per cycle; a held result stalls the input only when both
//   registers are full.
// Reset: asynchronous, active low; all but the input and result data registers
//   return to their documented values at once, no clearing pass.
// The configuration port is always ready.
`default_nettype none

module keypad_idle_battery_supervisor #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10,
  parameter int unsigned SAMPLE_BITS         = 16
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  kibs_in_if.sink    in_i,
  kibs_out_if.source res_o,
  kibs_cfg_if.sink   cfg_i
);

  // input register
  logic        s1_valid_q;
  logic [4:0]  s1_mask_q;
  logic [15:0] s1_sample_q;

  logic                    out_valid_q;
  kibs_pkg::kibs_res_t     res_q, res_d;

  logic [15:0] dim_q, off_q;
  logic [7:0]  wake_q;

  logic [2:0]  held_q, held_d;
  logic [15:0] idle_q, idle_d, idle_eff;
  logic [7:0]  bright_q, bright_d;

  logic       adv, in_hold, release_key, single;
  logic [2:0] key_k;
  logic [4:0] held_mask;

  kibs_pkg::kibs_cfg_wr_t   cfg_wr;
  kibs_pkg::kibs_bat_stat_t bat;

  assign adv        = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  assign cfg_wr.en   = cfg_i.valid;
  assign cfg_wr.idx  = cfg_i.index;
  assign cfg_wr.data = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= kibs_pkg::DIM_RST;
      off_q  <= kibs_pkg::OFF_RST;
      wake_q <= kibs_pkg::WAKE_RST;
    end else if (cfg_wr.en) begin
      case (cfg_wr.idx)
        kibs_pkg::REG_DIM:  dim_q  <= cfg_wr.data;
        kibs_pkg::REG_OFF:  off_q  <= cfg_wr.data;
        kibs_pkg::REG_WAKE: wake_q <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_mask_q   <= in_i.button_mask;
      s1_sample_q <= in_i.battery_sample;
    end
  end

  always_comb begin
    key_k = '0;
    for (int k = 0; k < kibs_pkg::NUM_BUTTONS; k++) begin
      if (s1_mask_q == (5'd1 << k)) begin
        key_k = 3'(k);
      end
    end
  end

  assign single    = $onehot(s1_mask_q);
  assign held_mask = 5'd1 << (held_q - 3'd1);

  always_comb begin
    in_hold     = 1'b0;
    release_key = 1'b0;
    held_d      = held_q;
    if (held_q != 3'd0) begin
      if (s1_mask_q == held_mask) begin
        in_hold = 1'b1;
      end else begin
        release_key = 1'b1;
        held_d      = 3'd0;
      end
    end else if (single) begin
      held_d  = key_k + 3'd1;
      in_hold = 1'b1;
    end
  end

  // the release clears the idle count before the dim and standby checks
  assign idle_eff = release_key ? 16'd0 : idle_q;
  assign idle_d   = (&idle_eff) ? idle_eff : idle_eff + 16'd1;

  always_comb begin
    bright_d = bright_q;
    if (release_key && (idle_q > dim_q)) begin
      bright_d = wake_q;
    end
    if (!in_hold && (idle_eff > dim_q)) begin
      bright_d = '0;
    end
  end

  kibs_battery #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SAMPLE_BITS         (SAMPLE_BITS)
  ) u_battery (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .step_i   (adv && !in_hold),
    .sample_i (s1_sample_q),
    .stat_o   (bat)
  );

  always_comb begin
    res_d.key_valid          = release_key;
    res_d.key_code           = release_key ? (held_q - 3'd1) : 3'd0;
    res_d.display_brightness = bright_d;
    res_d.standby_request    = !in_hold && (idle_eff > off_q);
    res_d.battery_level      = bat.level;
    res_d.level_update       = bat.update;
    res_d.low_battery_off    = bat.shutdown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      idle_q      <= '0;
      bright_q    <= kibs_pkg::BRIGHT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        held_q   <= held_d;
        idle_q   <= idle_d;
        bright_q <= bright_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.key_valid          = res_q.key_valid;
  assign res_o.key_code           = res_q.key_code;
  assign res_o.display_brightness = res_q.display_brightness;
  assign res_o.standby_request    = res_q.standby_request;
  assign res_o.battery_level      = res_q.battery_level;
  assign res_o.level_update       = res_q.level_update;
  assign res_o.low_battery_off    = res_q.low_battery_off;

endmodule

`default_nettype wire

### hdl/kibs_battery.sv
`default_nettype none

module kibs_battery #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10,
  parameter int unsigned SAMPLE_BITS         = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire kibs_pkg::kibs_cfg_wr_t cfg_i,
  input  wire logic                   step_i,
  input  wire logic [15:0]            sample_i,
  output kibs_pkg::kibs_bat_stat_t    stat_o
);

  localparam int unsigned SW = (SAMPLE_BITS < kibs_pkg::INPUT_BITS) ?
                               SAMPLE_BITS : kibs_pkg::INPUT_BITS;
  localparam int unsigned CW    = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int unsigned SUM_W = SW + CW;
  // thresholds are kept pre-multiplied by the sample count
  localparam int unsigned TW    = kibs_pkg::INPUT_BITS + CW;

  localparam logic [TW-1:0] N_T       = TW'(SAMPLES_PER_AVERAGE);
  localparam logic [CW-1:0] N_C       = CW'(SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] FULL_LO_R = TW'(kibs_pkg::FULL_RST * SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] FULL_HI_R = TW'((kibs_pkg::FULL_RST + 1) * SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] MID_LO_R  = TW'(kibs_pkg::MID_RST * SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] MID_HI_R  = TW'((kibs_pkg::MID_RST + 1) * SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] LOW_LO_R  = TW'(kibs_pkg::LOW_RST * SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] LOW_HI_R  = TW'((kibs_pkg::LOW_RST + 1) * SAMPLES_PER_AVERAGE);
  localparam logic [TW-1:0] EMPTY_R   = TW'(kibs_pkg::EMPTY_RST * SAMPLES_PER_AVERAGE);

  logic [TW-1:0] full_lo_q, full_hi_q, mid_lo_q, mid_hi_q, low_lo_q, low_hi_q, empty_q;
  logic [TW-1:0] thr_lo, thr_hi;

  logic [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic [CW-1:0]    cnt_q, cnt_d, cnt_new;
  logic [1:0]       level_q, level_d;
  logic             latch_q, latch_d;
  logic             acc, done, upd;
  logic [TW-1:0]    sx;
  logic gt_full, lt_full, gt_mid, lt_mid, gt_low, lt_low, lt_empty, nz;

  // avg > T  <=>  sum >= (T+1)*N ; avg < T  <=>  sum < T*N
  assign thr_lo = TW'(cfg_i.data) * N_T;
  assign thr_hi = (TW'(cfg_i.data) + TW'(1)) * N_T;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_lo_q <= FULL_LO_R;
      full_hi_q <= FULL_HI_R;
      mid_lo_q  <= MID_LO_R;
      mid_hi_q  <= MID_HI_R;
      low_lo_q  <= LOW_LO_R;
      low_hi_q  <= LOW_HI_R;
      empty_q   <= EMPTY_R;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        kibs_pkg::REG_FULL: begin
          full_lo_q <= thr_lo;
          full_hi_q <= thr_hi;
        end
        kibs_pkg::REG_MID: begin
          mid_lo_q <= thr_lo;
          mid_hi_q <= thr_hi;
        end
        kibs_pkg::REG_LOW: begin
          low_lo_q <= thr_lo;
          low_hi_q <= thr_hi;
        end
        kibs_pkg::REG_EMPTY: empty_q <= thr_lo;
        default: ;
      endcase
    end
  end

  assign acc     = step_i && !latch_q;
  assign sum_new = sum_q + SUM_W'(sample_i[SW-1:0]);
  assign cnt_new = cnt_q + CW'(1);
  assign done    = acc && (cnt_new >= N_C);
  assign sx      = TW'(sum_new);

  assign gt_full  = sx >= full_hi_q;
  assign lt_full  = sx <  full_lo_q;
  assign gt_mid   = sx >= mid_hi_q;
  assign lt_mid   = sx <  mid_lo_q;
  assign gt_low   = sx >= low_hi_q;
  assign lt_low   = sx <  low_lo_q;
  assign lt_empty = sx <  empty_q;
  assign nz       = sx >= N_T;

  always_comb begin
    level_d = level_q;
    upd     = 1'b0;
    latch_d = latch_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    if (acc) begin
      sum_d = sum_new;
      cnt_d = cnt_new;
    end
    if (done) begin
      upd = 1'b1;
      if (gt_full) begin
        level_d = kibs_pkg::LVL_FULL;
      end else if (lt_full && gt_mid) begin
        level_d = kibs_pkg::LVL_MID;
      end else if (lt_mid && gt_low) begin
        level_d = kibs_pkg::LVL_LOW;
      end else if (lt_low) begin
        level_d = kibs_pkg::LVL_EMPTY;
      end else begin
        upd = 1'b0;  // average on a threshold or thresholds out of order
      end
      if (nz && lt_empty) begin
        latch_d = 1'b1;
      end else begin
        sum_d = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      level_q <= kibs_pkg::LVL_FULL;
      latch_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
      latch_q <= latch_d;
    end
  end

  assign stat_o.level    = level_d;
  assign stat_o.update   = upd;
  assign stat_o.shutdown = latch_d;

endmodule

`default_nettype wire

### hdl/kibs_checker.sv
`default_nettype none

module kibs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       key_valid,
  input wire logic [2:0] key_code,
  input wire logic [7:0] display_brightness,
  input wire logic       standby_request,
  input wire logic [1:0] battery_level,
  input wire logic       level_update,
  input wire logic       low_battery_off
);

  // set once a delivered item has shown the shutdown latch
  logic seen_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_off_q <= 1'b0;
    end else if (out_valid && out_ready && low_battery_off) begin
      seen_off_q <= 1'b1;
    end
  end

  a_code_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !key_valid |-> key_code == 3'd0)
    else $error("key_code nonzero without a key");

  a_release_no_standby: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && key_valid |-> !standby_request)
    else $error("standby requested on a key release");

  a_off_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && seen_off_q |-> low_battery_off && !level_update)
    else $error("shutdown latch dropped or averaging not frozen");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(key_valid) && $stable(key_code)
      && $stable(display_brightness) && $stable(standby_request)
      && $stable(battery_level) && $stable(level_update) && $stable(low_battery_off))
    else $error("stalled item changed");

endmodule

bind keypad_idle_battery_supervisor kibs_checker u_kibs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid          (res_o.valid),
  .out_ready          (res_o.ready),
  .key_valid          (res_o.key_valid),
  .key_code           (res_o.key_code),
  .display_brightness (res_o.display_brightness),
  .standby_request    (res_o.standby_request),
  .battery_level      (res_o.battery_level),
  .level_update       (res_o.level_update),
  .low_battery_off    (res_o.low_battery_off)
);

`default_nettype wire
